### rtl/core/urlencoded_form_tokenizer_assert.svh
// assertion macros for the form tokenizer
`ifndef URLENCODED_FORM_TOKENIZER_ASSERT_SVH
`define URLENCODED_FORM_TOKENIZER_ASSERT_SVH

// condition holds in the same cycle
`define UFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the following cycle
`define UFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/uft_pkg.sv
// types and constants of the form tokenizer
`timescale 1ns / 1ps
package uft_pkg;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic [7:0] MAX_PAIRS_RST = 8'd16;

	localparam logic [2:0] ROLE_SKIP  = 3'd0;
	localparam logic [2:0] ROLE_NAME  = 3'd1;
	localparam logic [2:0] ROLE_VALUE = 3'd2;
	localparam logic [2:0] ROLE_SEP   = 3'd3;
	localparam logic [2:0] ROLE_END   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_VALUE = 2'd1;
	localparam logic [1:0] ST_TOO_MANY = 2'd2;

	typedef enum logic [3:0] {
		PH_START   = 4'b0001,
		PH_NAME    = 4'b0010,
		PH_VALUE   = 4'b0100,
		PH_DISCARD = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [2:0] role;
		logic [7:0] pair_index;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] pair_count;
	} res_t;
endpackage

### rtl/core/uft_in_if.sv
// input byte channel
`timescale 1ns / 1ps
interface uft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

### rtl/core/uft_out_if.sv
// result channel
`timescale 1ns / 1ps
interface uft_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] role;
	logic [7:0] pair_index;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] pair_count;

	modport source (output valid, output role, output pair_index, output done_res,
		output status, output pair_count, input ready);
	modport sink (input valid, input role, input pair_index, input done_res,
		input status, input pair_count, output ready);
endinterface

### rtl/core/uft_cfg_if.sv
// max_pairs write channel
`timescale 1ns / 1ps
interface uft_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/uft_step.sv
// per-byte phase update and result tagging
`timescale 1ns / 1ps
module uft_step (
	input  uft_pkg::phase_t phase,
	input  logic [7:0]      pair_cnt,
	input  logic [7:0]      max_pairs,
	input  logic [7:0]      ch,
	output uft_pkg::phase_t phase_nxt,
	output logic [7:0]      pair_cnt_nxt,
	output uft_pkg::res_t   res
);
	import uft_pkg::*;

	logic       is_nul;
	logic       is_blank;
	logic       is_line_end;
	logic [8:0] cnt_inc;
	logic       too_many;
	phase_t     phase_new_msg;

	always_comb begin
		is_nul        = (ch == CH_NUL);
		is_blank      = (ch == CH_SP) || (ch inside {[CH_TAB:CH_CR]});
		is_line_end   = is_nul || (ch == CH_CR) || (ch == CH_LF);
		cnt_inc       = {1'b0, pair_cnt} + 9'd1;
		too_many      = (cnt_inc >= {1'b0, max_pairs});
		phase_new_msg = is_nul ? PH_START : PH_DISCARD;
	end

	always_comb begin
		phase_nxt      = phase;
		pair_cnt_nxt   = pair_cnt;
		res.role       = ROLE_SKIP;
		res.pair_index = pair_cnt;
		res.done_res   = 1'b0;
		res.status     = ST_OK;
		res.pair_count = 8'd0;
		case (phase)
			PH_START: begin
				if (is_nul) begin
					res.role       = ROLE_END;
					res.done_res   = 1'b1;
					res.pair_count = pair_cnt;
					phase_nxt      = PH_START;
					pair_cnt_nxt   = 8'd0;
				end else if (is_blank) begin
					res.role = ROLE_SKIP;
				end else if (ch == CH_EQ) begin
					res.role  = ROLE_SEP;
					phase_nxt = PH_VALUE;
				end else begin
					res.role  = ROLE_NAME;
					phase_nxt = PH_NAME;
				end
			end
			PH_NAME: begin
				if (is_line_end) begin
					res.role       = ROLE_END;
					res.done_res   = 1'b1;
					res.status     = ST_NO_VALUE;
					res.pair_count = pair_cnt;
					phase_nxt      = phase_new_msg;
					pair_cnt_nxt   = 8'd0;
				end else if (ch == CH_EQ) begin
					res.role  = ROLE_SEP;
					phase_nxt = PH_VALUE;
				end else begin
					res.role = ROLE_NAME;
				end
			end
			PH_VALUE: begin
				if (is_line_end) begin
					// the open pair counts as complete
					res.role       = ROLE_END;
					res.done_res   = 1'b1;
					res.pair_count = cnt_inc[7:0];
					phase_nxt      = phase_new_msg;
					pair_cnt_nxt   = 8'd0;
				end else if (ch == CH_AMP) begin
					res.role = ROLE_SEP;
					if (too_many) begin
						res.done_res   = 1'b1;
						res.status     = ST_TOO_MANY;
						res.pair_count = cnt_inc[7:0];
						phase_nxt      = PH_DISCARD;
						pair_cnt_nxt   = 8'd0;
					end else begin
						phase_nxt    = PH_START;
						pair_cnt_nxt = cnt_inc[7:0];
					end
				end else begin
					res.role = ROLE_VALUE;
				end
			end
			PH_DISCARD: begin
				if (is_nul) begin
					phase_nxt    = PH_START;
					pair_cnt_nxt = 8'd0;
				end
			end
			default: begin
				phase_nxt    = PH_START;
				pair_cnt_nxt = 8'd0;
			end
		endcase
	end
endmodule

### rtl/core/urlencoded_form_tokenizer.sv
// Form body tokenizer for application/x-www-form-urlencoded text.
// req carries one byte (ch) per request; rsp returns one tagged result per
// byte: role, pair_index, and on the message end or pair overflow done_res,
// status and pair_count. cfg writes max_pairs (reset 16); write only while
// idle. A byte passes the input register, then the result register; the
// phase update between them is combinational, so one byte per cycle flows
// through while rsp is not stalled.
// A stalled rsp holds the result register; req keeps taking bytes until the
// input register is also full, then req.ready drops until rsp drains.
// Reset (arst_n low) empties both stages, sets the phase to pair start, the
// pair counter to zero and max_pairs to 16. cfg.ready is always high.
`timescale 1ns / 1ps
`include "urlencoded_form_tokenizer_assert.svh"
module urlencoded_form_tokenizer (
	input logic      clk,
	input logic      arst_n,
	uft_in_if.sink   req,
	uft_out_if.source rsp,
	uft_cfg_if.sink  cfg
);
	import uft_pkg::*;

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       vld_s2;
	res_t       res_s2;

	phase_t     phase_q;
	logic [7:0] pair_cnt_q;
	logic [7:0] max_pairs_q;

	phase_t     phase_nxt;
	logic [7:0] pair_cnt_nxt;
	res_t       res_nxt;

	logic       adv_s2;
	logic       load_s2;

	assign adv_s2    = !vld_s2 || rsp.ready;
	assign load_s2   = vld_s1 && adv_s2;
	assign req.ready = !vld_s1 || adv_s2;
	assign cfg.ready = 1'b1;

	uft_step u_step (
		.phase        (phase_q),
		.pair_cnt     (pair_cnt_q),
		.max_pairs    (max_pairs_q),
		.ch           (ch_s1),
		.phase_nxt    (phase_nxt),
		.pair_cnt_nxt (pair_cnt_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			phase_q     <= PH_START;
			pair_cnt_q  <= 8'd0;
			max_pairs_q <= MAX_PAIRS_RST;
		end else begin
			if (req.ready) begin
				vld_s1 <= req.valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			// state moves with the byte entering the result register
			if (load_s2) begin
				phase_q    <= phase_nxt;
				pair_cnt_q <= pair_cnt_nxt;
			end
			if (cfg.valid && cfg.ready) begin
				max_pairs_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			ch_s1 <= req.ch;
		end
		if (load_s2) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp.valid      = vld_s2;
	assign rsp.role       = res_s2.role;
	assign rsp.pair_index = res_s2.pair_index;
	assign rsp.done_res   = res_s2.done_res;
	assign rsp.status     = res_s2.status;
	assign rsp.pair_count = res_s2.pair_count;

	`UFT_ASSERT_NEXT(a_overflow_discards, clk, arst_n,
		load_s2 && res_nxt.status == ST_TOO_MANY, phase_q == PH_DISCARD,
		"too-many-pairs request did not enter discard")
	`UFT_ASSERT_NEXT(a_done_clears_count, clk, arst_n,
		load_s2 && res_nxt.done_res, pair_cnt_q == 8'd0,
		"pair counter not cleared after message end")
	`UFT_ASSERT_NOW(a_end_is_done, clk, arst_n,
		vld_s2 && res_s2.role == ROLE_END, res_s2.done_res,
		"end role without done result")
endmodule

### verif/urlencoded_form_tokenizer_tb.sv
// self-checking testbench for the form body tokenizer
`timescale 1ns / 1ps
module urlencoded_form_tokenizer_tb;
	import uft_pkg::*;

	typedef struct {
		bit         typed;
		res_t       want;
	} hint_t;

	typedef struct {
		bit         is_cfg;
		bit         typed;
		logic [7:0] data;
		res_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	uft_in_if  req_bus ();
	uft_out_if rsp_bus ();
	uft_cfg_if cfg_bus ();

	urlencoded_form_tokenizer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	always #5 clk = ~clk;

	// tokenizer state as the testbench sees it
	phase_t     cur_phase = PH_START;
	logic [7:0] pairs_done = 8'd0;
	logic [7:0] pair_limit = MAX_PAIRS_RST;

	res_t  pending_tags[$];
	hint_t hints[$];
	int    mismatches = 0;
	int    items_sent = 0;
	bit    idle_on = 1'b1;
	row_t  script[$];

	res_t  predicted;
	res_t  wanted;
	hint_t hint_now;

	logic [7:0] blanks[6] = '{CH_SP, CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR};

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic res_t tokenize(input logic [7:0] c);
		res_t       r;
		logic [8:0] next;
		bit         line_end;
		r = '0;
		r.role = ROLE_SKIP;
		r.pair_index = pairs_done;
		next = {1'b0, pairs_done} + 9'd1;
		line_end = (c == CH_NUL || c == CH_CR || c == CH_LF);
		case (cur_phase)
			PH_START: begin
				if (c == CH_NUL) begin
					r.role = ROLE_END;
					r.done_res = 1'b1;
					r.pair_count = pairs_done;
					pairs_done = 8'd0;
				end else if (is_blank(c)) begin
					r.role = ROLE_SKIP;
				end else if (c == CH_EQ) begin
					r.role = ROLE_SEP;
					cur_phase = PH_VALUE;
				end else begin
					r.role = ROLE_NAME;
					cur_phase = PH_NAME;
				end
			end
			PH_NAME: begin
				if (line_end) begin
					r.role = ROLE_END;
					r.done_res = 1'b1;
					r.status = ST_NO_VALUE;
					r.pair_count = pairs_done;
					cur_phase = (c == CH_NUL) ? PH_START : PH_DISCARD;
					pairs_done = 8'd0;
				end else if (c == CH_EQ) begin
					r.role = ROLE_SEP;
					cur_phase = PH_VALUE;
				end else begin
					r.role = ROLE_NAME;
				end
			end
			PH_VALUE: begin
				if (line_end) begin
					// an open value still counts as a finished pair
					r.role = ROLE_END;
					r.done_res = 1'b1;
					r.pair_count = next[7:0];
					cur_phase = (c == CH_NUL) ? PH_START : PH_DISCARD;
					pairs_done = 8'd0;
				end else if (c == CH_AMP) begin
					r.role = ROLE_SEP;
					if (next >= {1'b0, pair_limit}) begin
						r.done_res = 1'b1;
						r.status = ST_TOO_MANY;
						r.pair_count = next[7:0];
						cur_phase = PH_DISCARD;
						pairs_done = 8'd0;
					end else begin
						pairs_done = next[7:0];
						cur_phase = PH_START;
					end
				end else begin
					r.role = ROLE_VALUE;
				end
			end
			default: begin
				if (c == CH_NUL) begin
					cur_phase = PH_START;
					pairs_done = 8'd0;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				predicted = tokenize(req_bus.ch);
				hint_now = hints.pop_front();
				pending_tags.push_back(hint_now.typed ? hint_now.want : predicted);
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (pending_tags.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					wanted = pending_tags.pop_front();
					check_field("role", wanted.role, rsp_bus.role);
					check_field("pair_index", wanted.pair_index, rsp_bus.pair_index);
					check_field("done_res", wanted.done_res, rsp_bus.done_res);
					check_field("status", wanted.status, rsp_bus.status);
					check_field("pair_count", wanted.pair_count, rsp_bus.pair_count);
				end
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		rsp_bus.ready <= idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
	end

	task automatic send_byte(input logic [7:0] c, input bit typed, input res_t want);
		hint_t h;
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 25) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		h.typed = typed;
		h.want = want;
		hints.push_back(h);
		req_bus.valid <= 1'b1;
		req_bus.ch <= c;
		do @(posedge clk); while (!req_bus.ready);
		items_sent++;
	endtask

	task automatic send(input logic [7:0] c);
		send_byte(c, 1'b0, '0);
	endtask

	task automatic wait_for_results();
		while (pending_tags.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_max_pairs(input logic [7:0] v);
		@(negedge clk);
		req_bus.valid <= 1'b0;
		wait_for_results();
		repeat (4) @(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= v;
		do @(posedge clk); while (!cfg_bus.ready);
		pair_limit = v;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [7:0] text_char(input bit head, input bit in_value);
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255));
		while (c == CH_CR || c == CH_LF || (in_value ? c == CH_AMP : c == CH_EQ) ||
			(head && is_blank(c)));
		return c;
	endfunction

	// one message: mostly well formed, with the various ways it can end
	task automatic send_message();
		int pairs;
		int n;
		pairs = ($urandom_range(0, 3) == 0 && pair_limit < 8) ? pair_limit + 1 :
			$urandom_range(0, 4);
		repeat ($urandom_range(0, 2)) send(blanks[$urandom_range(0, 5)]);
		for (int i = 0; i < pairs; i++) begin
			n = $urandom_range(0, 3);
			for (int k = 0; k < n; k++) send(text_char(k == 0, 1'b0));
			send(CH_EQ);
			n = $urandom_range(0, 3);
			for (int k = 0; k < n; k++) send(text_char(1'b0, 1'b1));
			if (i < pairs - 1)
				send(CH_AMP);
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: send(CH_NUL);
			6: begin
				send($urandom_range(0, 1) ? CH_CR : CH_LF);
				repeat ($urandom_range(0, 2)) send(8'($urandom_range(1, 255)));
				send(CH_NUL);
			end
			7: begin
				send(CH_AMP);
				send(CH_NUL);
			end
			8: begin
				send(text_char(1'b1, 1'b0));
				case ($urandom_range(0, 2))
					0: send(CH_NUL);
					1: send(CH_CR);
					default: send(CH_LF);
				endcase
				send(CH_NUL);
			end
			default: ;
		endcase
	endtask

	function automatic row_t byte_row(input logic [7:0] c);
		return '{1'b0, 1'b0, c, '0};
	endfunction

	function automatic row_t typed_row(input logic [7:0] c, input res_t w);
		return '{1'b0, 1'b1, c, w};
	endfunction

	function automatic row_t cfg_row(input logic [7:0] v);
		return '{1'b1, 1'b0, v, '0};
	endfunction

	initial begin
		#(5_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [7:0] limits[7];
		limits = '{8'd255, 8'd16, 8'd2, 8'd0, 8'd3, 8'd1, 8'd7};
		limits[3] = 8'($urandom_range(1, 254));

		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.ch = 8'd0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = 8'd0;

		// directed: blanks, empty name, every way a message ends, pair limit
		script.push_back(typed_row(CH_NUL, {ROLE_END, 8'd0, 1'b1, ST_OK, 8'd0}));
		script.push_back(typed_row(CH_SP, {ROLE_SKIP, 8'd0, 1'b0, ST_OK, 8'd0}));
		script.push_back(byte_row(CH_TAB));
		script.push_back(byte_row(CH_CR));
		script.push_back(byte_row(CH_LF));
		script.push_back(byte_row(8'h0B));
		script.push_back(byte_row(8'h0C));
		script.push_back(byte_row("a"));
		script.push_back(byte_row(CH_EQ));
		script.push_back(byte_row("b"));
		script.push_back(byte_row(CH_AMP));
		script.push_back(byte_row(CH_EQ));
		script.push_back(byte_row(8'hFF));
		script.push_back(typed_row(CH_NUL, {ROLE_END, 8'd1, 1'b1, ST_OK, 8'd2}));
		script.push_back(byte_row("x"));
		script.push_back(typed_row(CH_CR, {ROLE_END, 8'd0, 1'b1, ST_NO_VALUE, 8'd0}));
		script.push_back(byte_row("q"));
		script.push_back(byte_row(CH_NUL));
		script.push_back(byte_row(CH_EQ));
		script.push_back(byte_row("v"));
		script.push_back(byte_row(CH_LF));
		script.push_back(byte_row(CH_NUL));
		script.push_back(cfg_row(8'd1));
		script.push_back(byte_row("k"));
		script.push_back(byte_row(CH_EQ));
		script.push_back(typed_row(CH_AMP, {ROLE_SEP, 8'd0, 1'b1, ST_TOO_MANY, 8'd1}));
		script.push_back(byte_row(CH_NUL));
		script.push_back(cfg_row(8'd0));
		script.push_back(byte_row(CH_EQ));
		script.push_back(typed_row(CH_AMP, {ROLE_SEP, 8'd0, 1'b1, ST_TOO_MANY, 8'd1}));
		script.push_back(byte_row(CH_NUL));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_max_pairs(script[i].data);
			else
				send_byte(script[i].data, script[i].typed, script[i].want);
		end

		for (int p = 0; p < 7; p++) begin
			write_max_pairs(limits[p]);
			idle_on = (p != 2);
			if (limits[p] == 8'd255) begin
				// run the pair counter up to the pair limit of 255 with empty pairs
				repeat (256) begin
					send(CH_EQ);
					send(CH_AMP);
				end
				send(CH_NUL);
			end
			while (items_sent < 30 + (p + 1) * 275) begin
				if ($urandom_range(0, 9) < 8) begin
					send_message();
				end else begin
					repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1))
						send(CH_NUL);
				end
			end
		end

		@(negedge clk);
		req_bus.valid <= 1'b0;
		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

### urlencoded_form_tokenizer.f
+incdir+rtl/core
rtl/core/uft_pkg.sv
rtl/core/uft_in_if.sv
rtl/core/uft_out_if.sv
rtl/core/uft_cfg_if.sv
rtl/core/uft_step.sv
rtl/core/urlencoded_form_tokenizer.sv
verif/urlencoded_form_tokenizer_tb.sv
